// ===== design/disparity_to_point_reprojection_unit_defines.svh =====
// Assertion macros used by the port checker of the reprojection unit.
`ifndef DISPARITY_TO_POINT_REPROJECTION_UNIT_DEFINES_SVH
`define DISPARITY_TO_POINT_REPROJECTION_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define DPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("port rule violated one cycle after its trigger");

// Consequent must hold in the cycle after a reset edge.
`define DPR_ASSERT_AFTER_RESET(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("port state wrong after reset");

`endif

// ===== design/dpr_pkg.sv =====
// Shared types, constants and sizes of the disparity reprojection unit.
package dpr_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int SHIFT_W    = 11;
    localparam int DISP_W     = 8;
    localparam int INT_W      = 8;
    localparam int BORDER_W   = 8;
    localparam int SIZE_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int COEF_IDX_W = 4;
    localparam int COEF_NUM   = 16;
    localparam int WORD_W     = 32;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int MAT_ROWS   = 3;
    localparam int MAT_COLS   = 4;

    // column/row plus shift, signed
    localparam int SUM_W = ((COORD_BITS + 1 > SHIFT_W) ? COORD_BITS + 1 : SHIFT_W) + 1;
    // border window compare width
    localparam int CMP_W = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;
    // magnitude of a dividend: both terms of the lateral numerator and the depth term
    localparam int MAG_W = ((PROD_W - 2 - FRAC_BITS > SUM_W + WORD_W - 2) ?
                            PROD_W - 2 - FRAC_BITS : SUM_W + WORD_W - 2) + 2;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (MAG_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_STAGES * DIV_STEP;
    // magnitude stage, division stages, rounding stage, saturation stage
    localparam int DIV_LAT    = DIV_STAGES + 3;
    // matrix accumulator: three floored products plus offset
    localparam int ACC_W      = PROD_W - FRAC_BITS + 2;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = 2;
    localparam int RQ_DEPTH = 32;
    localparam int RQ_AW    = 5;

    localparam logic [COEF_IDX_W-1:0] COEF_CCX   = 4'd12;
    localparam logic [COEF_IDX_W-1:0] COEF_CCY   = 4'd13;
    localparam logic [COEF_IDX_W-1:0] COEF_BASE  = 4'd14;
    localparam logic [COEF_IDX_W-1:0] COEF_FOCAL = 4'd15;

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_LOAD  = 1'b1
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DISPARITY = 3'd0,
        CFG_X_SHIFT       = 3'd1,
        CFG_Y_SHIFT       = 3'd2,
        CFG_FRAME_BORDER  = 3'd3,
        CFG_FRAME_WIDTH   = 3'd4,
        CFG_FRAME_HEIGHT  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [DISP_W-1:0]          min_disparity;
        logic signed [SHIFT_W-1:0]  x_shift;
        logic signed [SHIFT_W-1:0]  y_shift;
        logic [BORDER_W-1:0]        frame_border;
        logic [SIZE_W-1:0]          frame_width;
        logic [SIZE_W-1:0]          frame_height;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        min_disparity: 8'd1,
        x_shift:       11'sd0,
        y_shift:       11'sd0,
        frame_border:  8'd0,
        frame_width:   13'd640,
        frame_height:  13'd480
    };

    typedef struct packed {
        t_func                     func;
        logic [COORD_BITS-1:0]     pixel_x;
        logic [COORD_BITS-1:0]     pixel_y;
        logic [DISP_W-1:0]         disparity;
        logic [INT_W-1:0]          intensity;
        logic [COEF_IDX_W-1:0]     coef_index;
        logic signed [WORD_W-1:0]  coef_value;
    } t_cmd;

    typedef struct packed {
        logic signed [WORD_W-1:0]  point_x;
        logic signed [WORD_W-1:0]  point_y;
        logic signed [WORD_W-1:0]  point_z;
        logic [INT_W-1:0]          point_intensity;
    } t_result;

endpackage

// ===== design/dpr_front.sv =====
// Front end: takes input words, drops pixels outside the window or below the minimum disparity, queues the rest.
module dpr_front import dpr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_push,
    input  t_cmd  i_item,
    output logic  o_full,
    output logic  o_cmd_valid,
    output t_cmd  o_cmd,
    input  logic  i_cmd_take
);

    t_cmd              r_mem [CQ_DEPTH];
    logic [CQ_AW-1:0]  r_wr_ptr;
    logic [CQ_AW-1:0]  r_rd_ptr;
    logic [CQ_AW:0]    r_count;
    logic [CQ_AW:0]    n_count;

    logic [CMP_W-1:0]  w_x;
    logic [CMP_W-1:0]  w_y;
    logic [CMP_W-1:0]  w_border;
    logic              w_keep_x;
    logic              w_keep_y;
    logic              w_keep_d;
    logic              w_write;
    logic              w_take;

    assign w_x      = CMP_W'(i_item.pixel_x);
    assign w_y      = CMP_W'(i_item.pixel_y);
    assign w_border = CMP_W'(i_cfg.frame_border);

    // window runs from border-1 to size-border-1
    assign w_keep_x = !((w_x + CMP_W'(1) < w_border) ||
                        (w_x + w_border >= CMP_W'(i_cfg.frame_width)));
    assign w_keep_y = !((w_y + CMP_W'(1) < w_border) ||
                        (w_y + w_border >= CMP_W'(i_cfg.frame_height)));
    // zero disparity is dropped even with a zero minimum
    assign w_keep_d = (i_item.disparity != '0) && (i_item.disparity >= i_cfg.min_disparity);

    assign o_full      = (r_count == (CQ_AW + 1)'(CQ_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];

    assign w_write = i_push && !o_full &&
                     ((i_item.func == FUNC_LOAD) || (w_keep_x && w_keep_y && w_keep_d));
    assign w_take  = i_cmd_take && o_cmd_valid;

    assign n_count = r_count + (CQ_AW + 1)'(w_write) - (CQ_AW + 1)'(w_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_write) begin
                r_wr_ptr <= r_wr_ptr + CQ_AW'(1);
            end
            if (w_take) begin
                r_rd_ptr <= r_rd_ptr + CQ_AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/dpr_div_pipe.sv =====
// Pipelined floor division of a signed numerator by a disparity byte, saturated to 32 bits.
module dpr_div_pipe import dpr_pkg::*; (
    input  logic                      i_clk,
    input  logic signed [PROD_W-1:0]  i_num,
    input  logic [DISP_W-1:0]         i_den,
    output logic signed [WORD_W-1:0]  o_quot
);

    typedef struct packed {
        logic [DIV_W-1:0]   num;
        logic [DISP_W-1:0]  rem;
    } t_dstate;

    localparam logic [WORD_W-1:0] HALF_RANGE = {1'b1, {(WORD_W - 1){1'b0}}};
    localparam logic [WORD_W-1:0] POS_MAX    = {1'b0, {(WORD_W - 1){1'b1}}};

    // restoring division, DIV_STEP quotient bits per stage
    function automatic t_dstate div_step(input t_dstate s, input logic [DISP_W-1:0] den);
        t_dstate          r;
        logic [DISP_W:0]  t;
        r = s;
        for (int k = 0; k < DIV_STEP; k++) begin
            t     = {r.rem, r.num[DIV_W-1]};
            r.num = {r.num[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                t        = t - {1'b0, den};
                r.num[0] = 1'b1;
            end
            r.rem = t[DISP_W-1:0];
        end
        return r;
    endfunction

    logic                      r_neg;
    logic [DIV_W-1:0]          r_mag;
    logic [DISP_W-1:0]         r_den;
    t_dstate                   r_st [DIV_STAGES];
    logic [DISP_W-1:0]         r_dn [DIV_STAGES];
    logic                      r_sg [DIV_STAGES];
    t_dstate                   w_st_in [DIV_STAGES];
    logic [DISP_W-1:0]         w_dn_in [DIV_STAGES];
    logic                      w_sg_in [DIV_STAGES];
    logic [DIV_W-1:0]          r_qa;
    logic                      r_qneg;
    logic signed [WORD_W-1:0]  r_quot;
    logic [DIV_W-WORD_W-1:0]   w_hi;
    logic [WORD_W-1:0]         w_lo;

    always_ff @(posedge i_clk) begin
        r_neg <= i_num[PROD_W-1];
        r_mag <= DIV_W'(i_num[PROD_W-1] ? -i_num : i_num);
        r_den <= i_den;
    end

    always_comb begin
        w_st_in[0].num = r_mag;
        w_st_in[0].rem = '0;
        w_dn_in[0]     = r_den;
        w_sg_in[0]     = r_neg;
        for (int k = 1; k < DIV_STAGES; k++) begin
            w_st_in[k] = r_st[k-1];
            w_dn_in[k] = r_dn[k-1];
            w_sg_in[k] = r_sg[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            r_st[k] <= div_step(w_st_in[k], w_dn_in[k]);
            r_dn[k] <= w_dn_in[k];
            r_sg[k] <= w_sg_in[k];
        end
    end

    // round the magnitude up for a negative numerator with a remainder: floor
    always_ff @(posedge i_clk) begin
        r_qa   <= r_st[DIV_STAGES-1].num +
                  DIV_W'(r_sg[DIV_STAGES-1] && (r_st[DIV_STAGES-1].rem != '0));
        r_qneg <= r_sg[DIV_STAGES-1];
    end

    assign w_hi = r_qa[DIV_W-1:WORD_W];
    assign w_lo = r_qa[WORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_qneg) begin
            if ((w_hi != '0) || (w_lo > HALF_RANGE)) begin
                r_quot <= $signed(HALF_RANGE);
            end else begin
                r_quot <= $signed(-w_lo);
            end
        end else begin
            if ((w_hi != '0) || w_lo[WORD_W-1]) begin
                r_quot <= $signed(POS_MAX);
            end else begin
                r_quot <= $signed(w_lo);
            end
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== design/dpr_back.sv =====
// Back end: coefficient table, camera products, three divider lanes and the affine map.
module dpr_back import dpr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_cmd_valid,
    input  t_cmd     i_cmd,
    output logic     o_cmd_take,
    input  logic     i_res_pop,
    output logic     o_res_valid,
    output t_result  o_res
);

    logic signed [WORD_W-1:0]        r_coef [COEF_NUM];
    logic [RQ_AW:0]                  r_inflight;

    logic                            w_pixel;
    logic                            w_pipe_busy;
    logic                            w_issue;
    logic                            w_load;

    logic signed [SUM_W-1:0]         w_sx;
    logic signed [SUM_W-1:0]         w_sy;
    logic signed [SUM_W+WORD_W-1:0]  w_p1x;
    logic signed [SUM_W+WORD_W-1:0]  w_p1y;
    logic signed [PROD_W-1:0]        w_p2x;
    logic signed [PROD_W-1:0]        w_p2y;
    logic signed [PROD_W-1:0]        w_fb;

    logic                            r_s1_vld;
    logic [DISP_W-1:0]               r_s1_d;
    logic [INT_W-1:0]                r_s1_int;
    logic signed [PROD_W-1:0]        r_s1_p1x;
    logic signed [PROD_W-1:0]        r_s1_p1y;
    logic signed [PROD_W-1:0]        r_s1_p2x;
    logic signed [PROD_W-1:0]        r_s1_p2y;
    logic signed [PROD_W-1:0]        r_s1_fb;

    logic                            r_s2_vld;
    logic [DISP_W-1:0]               r_s2_d;
    logic [INT_W-1:0]                r_s2_int;
    logic signed [PROD_W-1:0]        r_s2_numx;
    logic signed [PROD_W-1:0]        r_s2_numy;
    logic signed [PROD_W-1:0]        r_s2_numz;

    logic                            r_dl_vld [DIV_LAT];
    logic [INT_W-1:0]                r_dl_int [DIV_LAT];
    logic                            w_dl_busy;

    logic signed [WORD_W-1:0]        w_p [MAT_ROWS];
    logic signed [PROD_W-1:0]        w_mprod [MAT_ROWS][MAT_ROWS];

    logic                            r_m1_vld;
    logic [INT_W-1:0]                r_m1_int;
    logic signed [PROD_W-1:0]        r_m1_prod [MAT_ROWS][MAT_ROWS];
    logic signed [WORD_W-1:0]        r_m1_off [MAT_ROWS];

    logic                            r_m2_vld;
    logic [INT_W-1:0]                r_m2_int;
    logic signed [ACC_W-1:0]         r_m2_acc [MAT_ROWS];

    logic                            r_m3_vld;
    t_result                         r_m3_res;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-WORD_W:0] hi;
        hi = v[ACC_W-1:WORD_W-1];
        if ((hi == '0) || (hi == '1)) begin
            return $signed(v[WORD_W-1:0]);
        end else if (v[ACC_W-1]) begin
            return $signed({1'b1, {(WORD_W - 1){1'b0}}});
        end else begin
            return $signed({1'b0, {(WORD_W - 1){1'b1}}});
        end
    endfunction

    // issue control: pixels need a result slot, loads wait for an empty pipe
    always_comb begin
        w_dl_busy = 1'b0;
        for (int k = 0; k < DIV_LAT; k++) begin
            w_dl_busy = w_dl_busy | r_dl_vld[k];
        end
    end

    assign w_pipe_busy = r_s1_vld | r_s2_vld | w_dl_busy | r_m1_vld | r_m2_vld | r_m3_vld;
    assign w_pixel     = (i_cmd.func == FUNC_PIXEL);
    assign o_cmd_take  = i_cmd_valid &&
                         (w_pixel ? (r_inflight < (RQ_AW + 1)'(RQ_DEPTH)) : !w_pipe_busy);
    assign w_issue     = o_cmd_take && w_pixel;
    assign w_load      = o_cmd_take && !w_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
            for (int k = 0; k < COEF_NUM; k++) begin
                r_coef[k] <= '0;
            end
        end else begin
            r_inflight <= r_inflight + (RQ_AW + 1)'(w_issue) - (RQ_AW + 1)'(i_res_pop);
            if (w_load) begin
                r_coef[i_cmd.coef_index] <= i_cmd.coef_value;
            end
        end
    end

    // camera-space products
    assign w_sx  = $signed(SUM_W'(i_cmd.pixel_x)) + SUM_W'(i_cfg.x_shift);
    assign w_sy  = $signed(SUM_W'(i_cmd.pixel_y)) + SUM_W'(i_cfg.y_shift);
    assign w_p1x = w_sx * r_coef[COEF_BASE];
    assign w_p1y = w_sy * r_coef[COEF_BASE];
    assign w_p2x = r_coef[COEF_CCX] * r_coef[COEF_BASE];
    assign w_p2y = r_coef[COEF_CCY] * r_coef[COEF_BASE];
    assign w_fb  = r_coef[COEF_FOCAL] * r_coef[COEF_BASE];

    always_ff @(posedge i_clk) begin
        r_s1_d    <= i_cmd.disparity;
        r_s1_int  <= i_cmd.intensity;
        r_s1_p1x  <= PROD_W'(w_p1x);
        r_s1_p1y  <= PROD_W'(w_p1y);
        r_s1_p2x  <= w_p2x;
        r_s1_p2y  <= w_p2y;
        r_s1_fb   <= w_fb;

        // subtract the principal point term, rounded up
        r_s2_d    <= r_s1_d;
        r_s2_int  <= r_s1_int;
        r_s2_numx <= r_s1_p1x + ((-r_s1_p2x) >>> FRAC_BITS);
        r_s2_numy <= r_s1_p1y + ((-r_s1_p2y) >>> FRAC_BITS);
        r_s2_numz <= r_s1_fb >>> FRAC_BITS;
    end

    dpr_div_pipe u_div_x (
        .i_clk  (i_clk),
        .i_num  (r_s2_numx),
        .i_den  (r_s2_d),
        .o_quot (w_p[0])
    );

    dpr_div_pipe u_div_y (
        .i_clk  (i_clk),
        .i_num  (r_s2_numy),
        .i_den  (r_s2_d),
        .o_quot (w_p[1])
    );

    dpr_div_pipe u_div_z (
        .i_clk  (i_clk),
        .i_num  (r_s2_numz),
        .i_den  (r_s2_d),
        .o_quot (w_p[2])
    );

    // hold intensity alongside the divider lanes
    always_ff @(posedge i_clk) begin
        r_dl_int[0] <= r_s2_int;
        for (int k = 1; k < DIV_LAT; k++) begin
            r_dl_int[k] <= r_dl_int[k-1];
        end
    end

    // affine map
    always_comb begin
        for (int r = 0; r < MAT_ROWS; r++) begin
            for (int j = 0; j < MAT_ROWS; j++) begin
                w_mprod[r][j] = r_coef[r * MAT_COLS + j] * w_p[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_int <= r_dl_int[DIV_LAT-1];
        r_m2_int <= r_m1_int;
        for (int r = 0; r < MAT_ROWS; r++) begin
            r_m1_off[r] <= r_coef[r * MAT_COLS + MAT_COLS - 1];
            for (int j = 0; j < MAT_ROWS; j++) begin
                r_m1_prod[r][j] <= w_mprod[r][j];
            end
            r_m2_acc[r] <= ACC_W'(r_m1_off[r]) +
                           ACC_W'(r_m1_prod[r][0] >>> FRAC_BITS) +
                           ACC_W'(r_m1_prod[r][1] >>> FRAC_BITS) +
                           ACC_W'(r_m1_prod[r][2] >>> FRAC_BITS);
        end
        r_m3_res.point_x         <= sat_word(r_m2_acc[0]);
        r_m3_res.point_y         <= sat_word(r_m2_acc[1]);
        r_m3_res.point_z         <= sat_word(r_m2_acc[2]);
        r_m3_res.point_intensity <= r_m2_int;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_dl_vld[k] <= 1'b0;
            end
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
        end else begin
            r_s1_vld    <= w_issue;
            r_s2_vld    <= r_s1_vld;
            r_dl_vld[0] <= r_s2_vld;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_dl_vld[k] <= r_dl_vld[k-1];
            end
            r_m1_vld <= r_dl_vld[DIV_LAT-1];
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
        end
    end

    assign o_res_valid = r_m3_vld;
    assign o_res       = r_m3_res;

endmodule

// ===== design/dpr_result_queue.sv =====
// Result queue: holds finished points until the consumer pops them.
module dpr_result_queue import dpr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_result  i_data,
    input  logic     i_pop,
    output logic     o_empty,
    output t_result  o_data
);

    t_result           r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0]  r_wr_ptr;
    logic [RQ_AW-1:0]  r_rd_ptr;
    logic [RQ_AW:0]    r_count;
    logic              w_pop;

    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && !o_empty;

    // no overflow check: the back end never issues past the free slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + RQ_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + RQ_AW'(1);
            end
            r_count <= r_count + (RQ_AW + 1)'(i_push) - (RQ_AW + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/disparity_to_point_reprojection_unit.sv =====
// Disparity-to-point reprojection unit. Pixel words (func 0) are checked against the border
// window and the minimum disparity; rejected pixels vanish at the input and take no slot.
// Kept pixels become 3D points X, Y, Z = lateral*baseline/d and focal*baseline/d, mapped
// through the 3x4 affine matrix, in signed Q16.16 with floor rounding and 32-bit saturation.
// Load words (func 1) write one of 16 coefficients (matrix row-major, then ccx, ccy,
// baseline, focal). Throughput is one pixel per clock while a result slot is free and no load
// is waiting for the pipeline to drain. A point reaches the result side through the command
// queue, two product stages, 15 in the divider lanes (12 of them the 4-bit-per-stage restoring
// division by the disparity byte), three for the affine map and the result queue. A load waits
// in the 4-word command queue until the arithmetic pipeline is empty and then applies to all
// later pixels only. The 32-word result queue lets pushes continue while results wait;
// configuration writes are taken every cycle and must be made while the unit is idle.
// No clearing pass after reset.
module disparity_to_point_reprojection_unit import dpr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_func,
    input  logic [COORD_BITS-1:0]     i_pixel_x,
    input  logic [COORD_BITS-1:0]     i_pixel_y,
    input  logic [DISP_W-1:0]         i_disparity,
    input  logic [INT_W-1:0]          i_intensity,
    input  logic [COEF_IDX_W-1:0]     i_coef_index,
    input  logic signed [WORD_W-1:0]  i_coef_value,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [WORD_W-1:0]  o_point_x,
    output logic signed [WORD_W-1:0]  o_point_y,
    output logic signed [WORD_W-1:0]  o_point_z,
    output logic [INT_W-1:0]          o_point_intensity
);

    t_cfg     r_cfg;
    t_cmd     w_item;
    t_cmd     w_cmd;
    logic     w_cmd_valid;
    logic     w_cmd_take;
    logic     w_res_valid;
    t_result  w_res_in;
    t_result  w_res_out;
    logic     w_res_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_DISPARITY: r_cfg.min_disparity <= i_cfg_data[DISP_W-1:0];
                CFG_X_SHIFT:       r_cfg.x_shift       <= $signed(i_cfg_data[SHIFT_W-1:0]);
                CFG_Y_SHIFT:       r_cfg.y_shift       <= $signed(i_cfg_data[SHIFT_W-1:0]);
                CFG_FRAME_BORDER:  r_cfg.frame_border  <= i_cfg_data[BORDER_W-1:0];
                CFG_FRAME_WIDTH:   r_cfg.frame_width   <= i_cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT:  r_cfg.frame_height  <= i_cfg_data[SIZE_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        w_item.func       = t_func'(i_func);
        w_item.pixel_x    = i_pixel_x;
        w_item.pixel_y    = i_pixel_y;
        w_item.disparity  = i_disparity;
        w_item.intensity  = i_intensity;
        w_item.coef_index = i_coef_index;
        w_item.coef_value = i_coef_value;
    end

    dpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_item      (w_item),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    dpr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_res_pop   (w_res_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res_in)
    );

    dpr_result_queue u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_out)
    );

    assign w_res_pop         = pop && !empty;
    assign o_point_x         = w_res_out.point_x;
    assign o_point_y         = w_res_out.point_y;
    assign o_point_z         = w_res_out.point_z;
    assign o_point_intensity = w_res_out.point_intensity;

endmodule

// ===== design/dpr_port_checker.sv =====
// Port-level checks of the reprojection unit, bound to the top level.
`include "disparity_to_point_reprojection_unit_defines.svh"

module dpr_port_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         push,
    input logic         full,
    input logic         empty,
    input logic         pop,
    input logic [31:0]  o_point_x,
    input logic [31:0]  o_point_y,
    input logic [31:0]  o_point_z,
    input logic [7:0]   o_point_intensity
);

    // both queues come out of reset with nothing in them
    `DPR_ASSERT_AFTER_RESET(a_reset_queues, i_clk, i_rst_n, empty && !full)

    // the command queue only fills through pushes
    `DPR_ASSERT_NEXT(a_full_needs_push, i_clk, i_rst_n, !full && !push, !full)

    // a waiting word stays until popped, whatever the pipeline delivers behind it
    `DPR_ASSERT_NEXT(a_head_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_point_x) && $stable(o_point_y) && $stable(o_point_z) && $stable(o_point_intensity))

endmodule

bind disparity_to_point_reprojection_unit dpr_port_checker u_dpr_port_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .push              (push),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .o_point_x         (o_point_x),
    .o_point_y         (o_point_y),
    .o_point_z         (o_point_z),
    .o_point_intensity (o_point_intensity)
);
